// ===== rtl/core/lcdnw_pkg.sv =====
// Package for the LCD nibble writer: request codes, the init command table
// and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package lcdnw_pkg;

   localparam int unsigned REQ_W   = 2;
   localparam int unsigned VALUE_W = 16;
   localparam int unsigned PORT_W  = 2;
   localparam int unsigned NIB_W   = 4;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned IDX_W   = 3;
   localparam int unsigned NUM_DIGITS = 5;
   localparam int unsigned INIT_LEN   = 6;

   localparam logic [REQ_W-1:0] REQ_INIT    = 2'd0;
   localparam logic [REQ_W-1:0] REQ_COMMAND = 2'd1;
   localparam logic [REQ_W-1:0] REQ_DATA    = 2'd2;
   localparam logic [REQ_W-1:0] REQ_NUMBER  = 2'd3;

   // Reciprocal of ten: (x * 52429) >> 19 is exact for 16-bit x
   localparam logic [VALUE_W-1:0] RECIP_TEN   = 16'd52429;
   localparam int unsigned        RECIP_SHIFT = 19;
   localparam logic [BYTE_W-1:0]  ASCII_ZERO  = 8'h30;

   typedef struct packed {
      logic load;        // capture a new request
      logic conv_step;   // one divide-by-ten step
      logic emit;        // load the output register
      logic emit_low;    // select low nibble of current byte
      logic emit_last;   // flag this nibble as final
      logic advance;     // move to the next byte
   } lcdnw_cmd_type;

   typedef struct packed {
      logic conv_done;
      logic last_byte;
   } lcdnw_status_type;

   function automatic logic [BYTE_W-1:0] init_byte(input logic [IDX_W-1:0] idx);
      logic [BYTE_W-1:0] b;
      case (idx)
         3'd0:    b = 8'h03;
         3'd1:    b = 8'h02;
         3'd2:    b = 8'h28;
         3'd3:    b = 8'h01;
         3'd4:    b = 8'h06;
         3'd5:    b = 8'h0C;
         default: b = 8'h0C;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lcdnw_datapath.sv =====
// Datapath of the LCD nibble writer: request capture, decimal conversion,
// byte selection and the output register. Depends on lcdnw_pkg.
`default_nettype none

module lcdnw_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [lcdnw_pkg::REQ_W-1:0]      req_type,
   input  wire logic [lcdnw_pkg::VALUE_W-1:0]    req_operand_value,
   input  wire logic                             csr_wr_en,
   input  wire logic [lcdnw_pkg::PORT_W-1:0]     csr_wr_data,
   input  wire lcdnw_pkg::lcdnw_cmd_type         cmd,
   output      lcdnw_pkg::lcdnw_status_type      status,
   output      logic                             rsp_reg_select,
   output      logic [lcdnw_pkg::NIB_W-1:0]      rsp_nibble,
   output      logic [lcdnw_pkg::PORT_W-1:0]     rsp_port,
   output      logic                             rsp_last
);

   logic [lcdnw_pkg::PORT_W-1:0]  lcd_port_ff;
   logic [lcdnw_pkg::REQ_W-1:0]   mode_ff, mode_in;
   logic [lcdnw_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [lcdnw_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic [lcdnw_pkg::NIB_W-1:0]   digits_ff [lcdnw_pkg::NUM_DIGITS];

   logic [2*lcdnw_pkg::VALUE_W-1:0] product;
   logic [lcdnw_pkg::VALUE_W-1:0]   quot;
   logic [lcdnw_pkg::VALUE_W-1:0]   rem_full;
   logic [lcdnw_pkg::NIB_W-1:0]     rem;
   logic [lcdnw_pkg::BYTE_W-1:0]    cur_byte;
   logic                            cur_rs;
   logic                            conv_done;
   logic                            last_byte;

   logic                            rs_ff;
   logic [lcdnw_pkg::NIB_W-1:0]     nib_ff;
   logic [lcdnw_pkg::PORT_W-1:0]    port_ff;
   logic                            last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lcd_port_ff <= '0;
      end else if (csr_wr_en) begin
         lcd_port_ff <= csr_wr_data;
      end
   end

   // Divide by ten through the reciprocal, remainder by shift-and-subtract
   assign product  = value_ff * lcdnw_pkg::RECIP_TEN;
   assign quot     = lcdnw_pkg::VALUE_W'(product >> lcdnw_pkg::RECIP_SHIFT);
   assign rem_full = value_ff - (quot << 3) - (quot << 1);
   assign rem      = rem_full[lcdnw_pkg::NIB_W-1:0];

   assign conv_done = (quot == '0) ||
                      (idx_ff == lcdnw_pkg::IDX_W'(lcdnw_pkg::NUM_DIGITS - 1));

   assign status = '{conv_done: conv_done, last_byte: last_byte};

   always_comb begin
      mode_in  = mode_ff;
      value_in = value_ff;
      idx_in   = idx_ff;
      if (cmd.load) begin
         mode_in  = req_type;
         value_in = req_operand_value;
         idx_in   = '0;
      end else if (cmd.conv_step) begin
         value_in = quot;
         if (!conv_done) begin
            idx_in = idx_ff + 1'b1;
         end
      end else if (cmd.advance) begin
         // init walks the table upward, digits go out most significant first
         if (mode_ff == lcdnw_pkg::REQ_NUMBER) begin
            idx_in = idx_ff - 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      value_ff <= value_in;
      idx_ff   <= idx_in;
      if (cmd.conv_step) begin
         digits_ff[idx_ff] <= rem;
      end
   end

   always_comb begin
      cur_byte  = value_ff[lcdnw_pkg::BYTE_W-1:0];
      cur_rs    = 1'b0;
      last_byte = 1'b1;
      case (mode_ff)
         lcdnw_pkg::REQ_INIT: begin
            cur_byte  = lcdnw_pkg::init_byte(idx_ff);
            last_byte = (idx_ff == lcdnw_pkg::IDX_W'(lcdnw_pkg::INIT_LEN - 1));
         end
         lcdnw_pkg::REQ_COMMAND: begin
            cur_rs = 1'b0;
         end
         lcdnw_pkg::REQ_DATA: begin
            cur_rs = 1'b1;
         end
         lcdnw_pkg::REQ_NUMBER: begin
            cur_rs    = 1'b1;
            cur_byte  = lcdnw_pkg::ASCII_ZERO
                        + lcdnw_pkg::BYTE_W'(digits_ff[idx_ff]);
            last_byte = (idx_ff == '0);
         end
         default: begin
            cur_rs = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rs_ff   <= cur_rs;
         nib_ff  <= cmd.emit_low ? cur_byte[lcdnw_pkg::NIB_W-1:0]
                                 : cur_byte[lcdnw_pkg::BYTE_W-1:lcdnw_pkg::NIB_W];
         port_ff <= lcd_port_ff;
         last_ff <= cmd.emit_last;
      end
   end

   assign rsp_reg_select = rs_ff;
   assign rsp_nibble     = nib_ff;
   assign rsp_port       = port_ff;
   assign rsp_last       = last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lcdnw_ctrl.sv =====
// Controller of the LCD nibble writer: request handshake, conversion and
// nibble sequencing, output valid. Depends on lcdnw_pkg.
`default_nettype none

module lcdnw_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire logic [lcdnw_pkg::REQ_W-1:0]  req_type,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   input  wire lcdnw_pkg::lcdnw_status_type  status,
   output      lcdnw_pkg::lcdnw_cmd_type     cmd
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_CONV    = 2'd1;
   localparam logic [1:0] ST_SEND_HI = 2'd2;
   localparam logic [1:0] ST_SEND_LO = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       out_free;

   assign out_free  = !valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = (req_type == lcdnw_pkg::REQ_NUMBER) ? ST_CONV : ST_SEND_HI;
            end
         end
         ST_CONV: begin
            cmd.conv_step = 1'b1;
            if (status.conv_done) begin
               state_in = ST_SEND_HI;
            end
         end
         ST_SEND_HI: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_SEND_LO;
            end
         end
         ST_SEND_LO: begin
            if (out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_low  = 1'b1;
               cmd.emit_last = status.last_byte;
               cmd.advance   = !status.last_byte;
               state_in      = status.last_byte ? ST_IDLE : ST_SEND_HI;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold valid until taken, reload on each emitted nibble
   assign valid_in = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lcd_nibble_writer.sv =====
// Top level of the LCD nibble writer: controller plus datapath.
// Depends on lcdnw_pkg, lcdnw_ctrl and lcdnw_datapath.
//
// Usage:
//   Request channel (req_valid/req_ready): req_type selects init (six
//   commands), command byte, data byte or decimal number; req_operand_value
//   carries the byte (low 8 bits) or the 16-bit number.
//   Result channel (rsp_valid/rsp_ready): one nibble per result, high nibble
//   of each byte first, with register select, the configured port and a
//   last flag on the final nibble of the request.
//   csr_wr_en/csr_wr_data set the output pin group; write it only when idle.
// Timing:
//   A number request converts one decimal digit (1 to 5) per cycle in the
//   shared divide-by-ten step. Nibbles follow at one per cycle into the
//   output register while the result channel is not stalled; for byte
//   requests the first result passes through ST_SEND_HI into the output
//   register after acceptance. One request is in work at a time; req_ready
//   is high when idle.
// Reset clears the controller and the port register to zero; a stalled
// result holds its payload and the sequencer waits until it is taken.
`default_nettype none

module lcd_nibble_writer (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic [lcdnw_pkg::REQ_W-1:0]     req_type,
   input  wire logic [lcdnw_pkg::VALUE_W-1:0]   req_operand_value,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic                            rsp_reg_select,
   output      logic [lcdnw_pkg::NIB_W-1:0]     rsp_nibble,
   output      logic [lcdnw_pkg::PORT_W-1:0]    rsp_port,
   output      logic                            rsp_last,
   input  wire logic                            csr_wr_en,
   input  wire logic [lcdnw_pkg::PORT_W-1:0]    csr_wr_data
);

   lcdnw_pkg::lcdnw_cmd_type    cmd;
   lcdnw_pkg::lcdnw_status_type status;

   lcdnw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lcdnw_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_type          (req_type),
      .req_operand_value (req_operand_value),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .cmd               (cmd),
      .status            (status),
      .rsp_reg_select    (rsp_reg_select),
      .rsp_nibble        (rsp_nibble),
      .rsp_port          (rsp_port),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

// ===== rtl/core/lcdnw_checker.sv =====
// Port-level checks for the LCD nibble writer, bound to the top level.
// Depends on lcdnw_pkg and lcd_nibble_writer.
`default_nettype none

module lcdnw_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic                            rsp_reg_select,
   input wire logic [lcdnw_pkg::NIB_W-1:0]     rsp_nibble,
   input wire logic [lcdnw_pkg::PORT_W-1:0]    rsp_port,
   input wire logic                            rsp_last
);

   // no result pending right after reset
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // an accepted request blocks the next one in the following cycle
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous one in work");

   // a pending non-final nibble means the request is still in flight
   a_no_req_mid_sequence: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> !req_ready)
      else $error("request taken before last nibble");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_nibble)
                                     && $stable(rsp_last) && $stable(rsp_reg_select)
                                     && $stable(rsp_port)))
      else $error("stalled result changed");

endmodule

bind lcd_nibble_writer lcdnw_checker u_lcdnw_checker (.*);

`default_nettype wire
